### rtl/core/bsf_pkg.sv
package bsf_pkg;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES    = 2'd2;
    localparam int CFG_DATA_W = 16;

    localparam int SCR_W  = 13;
    localparam int LINE_W = 16;
    localparam logic [SCR_W-1:0]  SCREEN_WIDTH_RST  = 13'd800;
    localparam logic [SCR_W-1:0]  SCREEN_HEIGHT_RST = 13'd480;
    localparam logic [LINE_W-1:0] LINE_BYTES_RST    = 16'd3200;

    // Image size limits
    localparam int MAX_WIDTH_DEFAULT  = 4096;
    localparam int MAX_HEIGHT_DEFAULT = 4096;

    // Result fields
    localparam int ADDR_W  = 28;
    localparam int COLOR_W = 24;
    localparam int CODE_W  = 3;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    localparam logic [CODE_W-1:0] ERR_NOT_BMP    = 3'd0;
    localparam logic [CODE_W-1:0] ERR_BAD_SIZE   = 3'd1;
    localparam logic [CODE_W-1:0] ERR_BAD_DEPTH  = 3'd2;
    localparam logic [CODE_W-1:0] ERR_COMPRESSED = 3'd3;
    localparam logic [CODE_W-1:0] ERR_BAD_OFFSET = 3'd4;
    localparam logic [CODE_W-1:0] ERR_TOO_LARGE  = 3'd5;

    // Header layout
    localparam logic [5:0] OFS_MAGIC_B    = 6'd0;
    localparam logic [5:0] OFS_MAGIC_M    = 6'd1;
    localparam logic [5:0] OFS_DATA_START = 6'd10;
    localparam logic [5:0] OFS_WIDTH      = 6'd18;
    localparam logic [5:0] OFS_HEIGHT     = 6'd22;
    localparam logic [5:0] OFS_DEPTH      = 6'd28;
    localparam logic [5:0] OFS_COMP       = 6'd30;
    localparam logic [5:0] OFS_HDR_LAST   = 6'd53;
    localparam logic [31:0] HDR_LEN       = 32'd54;

    localparam logic [7:0] MAGIC_B = 8'h42;
    localparam logic [7:0] MAGIC_M = 8'h4D;

    localparam logic [15:0] DEPTH_24 = 16'd24;
    localparam logic [15:0] DEPTH_32 = 16'd32;

    // Byte lane within one pixel
    localparam logic [1:0] LANE_BLUE  = 2'd0;
    localparam logic [1:0] LANE_GREEN = 2'd1;
    localparam logic [1:0] LANE_RED   = 2'd2;
    localparam logic [1:0] LANE_PAD   = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [SCR_W-1:0]  screen_width;
        logic [SCR_W-1:0]  screen_height;
        logic [LINE_W-1:0] line_bytes;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic [ADDR_W-1:0]  write_address;
        logic [COLOR_W-1:0] pixel_color;
        logic [CODE_W-1:0]  error_code;
        logic               last_pixel;
    } result_t;

endpackage

### rtl/core/bsf_if.sv
// File byte channel
interface bsf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       start_of_file;

    modport source (output valid, file_byte, start_of_file, input ready);
    modport sink   (input valid, file_byte, start_of_file, output ready);
endinterface

// Result channel
interface bsf_result_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [bsf_pkg::ADDR_W-1:0]  write_address;
    logic [bsf_pkg::COLOR_W-1:0] pixel_color;
    logic [bsf_pkg::CODE_W-1:0]  error_code;
    logic                        last_pixel;

    modport source (output valid, kind, write_address, pixel_color, error_code, last_pixel,
                    input ready);
    modport sink   (input valid, kind, write_address, pixel_color, error_code, last_pixel,
                    output ready);
endinterface

// Configuration write channel
interface bsf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bsf_pkg::CFG_IDX_W-1:0]  index;
    logic [bsf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/bmp_stream_to_framebuffer.sv
// BMP byte stream to framebuffer pixel writes.
// bytes:   one file byte per item; start_of_file marks byte 0 of a new file.
// results: a pixel write (address in a 32-bit-per-pixel framebuffer, color
//          0xRRGGBB, last_pixel on the final drawn pixel) or one header error.
// cfg:     screen_width (0), screen_height (1), line_bytes (2); always ready.
// Only uncompressed 24- and 32-bit files pass the header check. Bottom-up
// images are flipped, the image is clipped to the screen and row padding is
// dropped. After an error or the last pixel, bytes are swallowed until the
// next start_of_file.
// Throughput: one byte per cycle while results are taken, set by the single parse
// stage that sits between the input register and the result register.
// Path: input register, then the parse stage, then the result register.
// Reset: control and config registers return to their defaults and the
// parser expects a header, with or without start_of_file on the first byte.
// Stall: while results.ready is low the input register and the result
// register each hold one item; bytes.ready then drops until results drain.
module bmp_stream_to_framebuffer #(
    parameter int MAX_WIDTH  = bsf_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = bsf_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    bsf_cfg_if.sink      cfg,
    bsf_byte_if.sink     bytes,
    bsf_result_if.source results
);

    bsf_pkg::cfg_t    cfg_regs;
    logic             res_valid;
    bsf_pkg::result_t res;

    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_byte_reg;
    logic             s1_sof_reg;
    logic             out_valid_reg, out_valid_next;
    bsf_pkg::result_t out_reg;
    logic             out_free;
    logic             advance;
    logic             in_take;

    bsf_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    bsf_decoder #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_decoder (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .file_byte     (s1_byte_reg),
        .start_of_file (s1_sof_reg),
        .cfg           (cfg_regs),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Pipeline flow control
    assign out_free    = !out_valid_reg || results.ready;
    assign advance     = s1_valid_reg && out_free;
    assign bytes.ready = !s1_valid_reg || advance;
    assign in_take     = bytes.valid && bytes.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (bytes.ready)
            s1_valid_next = bytes.valid;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = res_valid;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input and result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= bytes.file_byte;
            s1_sof_reg  <= bytes.start_of_file;
        end
        if (advance && res_valid)
            out_reg <= res;
    end

    assign results.valid         = out_valid_reg;
    assign results.kind          = out_reg.kind;
    assign results.write_address = out_reg.write_address;
    assign results.pixel_color   = out_reg.pixel_color;
    assign results.error_code    = out_reg.error_code;
    assign results.last_pixel    = out_reg.last_pixel;

endmodule

### rtl/core/bsf_cfg_regs.sv
module bsf_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    bsf_cfg_if.sink       cfg,
    output bsf_pkg::cfg_t regs
);

    bsf_pkg::cfg_t regs_reg;
    bsf_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                bsf_pkg::CFG_SCREEN_WIDTH:
                    regs_next.screen_width = cfg.data[bsf_pkg::SCR_W-1:0];
                bsf_pkg::CFG_SCREEN_HEIGHT:
                    regs_next.screen_height = cfg.data[bsf_pkg::SCR_W-1:0];
                bsf_pkg::CFG_LINE_BYTES:
                    regs_next.line_bytes = cfg.data[bsf_pkg::LINE_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.screen_width  <= bsf_pkg::SCREEN_WIDTH_RST;
            regs_reg.screen_height <= bsf_pkg::SCREEN_HEIGHT_RST;
            regs_reg.line_bytes    <= bsf_pkg::LINE_BYTES_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

### rtl/core/bsf_decoder.sv
module bsf_decoder #(
    parameter int MAX_WIDTH  = bsf_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = bsf_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       file_byte,
    input  logic             start_of_file,
    input  bsf_pkg::cfg_t    cfg,
    output logic             res_valid,
    output bsf_pkg::result_t res
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RSW = $clog2(4 * MAX_WIDTH + 1);
    localparam int CW  = (WW > bsf_pkg::SCR_W) ? WW : bsf_pkg::SCR_W;
    localparam int CH  = (HW > bsf_pkg::SCR_W) ? HW : bsf_pkg::SCR_W;
    localparam int XW  = (RSW > CW) ? RSW : CW;
    localparam int PW  = CH + bsf_pkg::LINE_W;

    // Parser control
    bsf_pkg::phase_t phase_reg, phase_next;
    logic [31:0]     pos_reg, pos_next;

    // Raw header fields
    logic [31:0] data_start_reg, data_start_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [15:0] depth_reg, depth_next;
    logic [31:0] comp_reg, comp_next;

    // Image geometry latched at the end of the header
    logic [WW-1:0]  img_w_reg, img_w_next;
    logic [HW-1:0]  abs_h_reg, abs_h_next;
    logic           neg_reg, neg_next;
    logic           bpb4_reg, bpb4_next;
    logic [RSW-1:0] stride_reg, stride_next;

    // Pixel walk counters
    logic [HW-1:0]  row_reg, row_next;
    logic [RSW-1:0] rbc_reg, rbc_next;
    logic [RSW-1:0] x_reg, x_next;
    logic [1:0]     k_reg, k_next;
    logic [15:0]    pix_reg, pix_next;

    bsf_pkg::phase_t cur_phase;
    logic [31:0]     pos;
    logic [5:0]      pos6;
    logic [1:0]      lane;
    logic            do_pixel;

    logic                       hdr_err;
    logic [bsf_pkg::CODE_W-1:0] hdr_code;
    logic [WW-1:0]              w_lo;
    logic [HW-1:0]              h_lo;
    logic [RSW+1:0]             three_w;
    logic [RSW-1:0]             rs_calc;

    logic [CW-1:0]   dw;
    logic [CH-1:0]   dh;
    logic            rows_done;
    logic            in_clip;
    logic            emit;
    logic            is_last;
    logic [HW:0]     row_inc;
    logic [RSW:0]    x_inc;
    logic [RSW:0]    rbc_inc;
    logic            row_end;
    logic            k_wrap;
    logic [CH-1:0]   sy;
    logic [PW-1:0]   prod;

    // Item view: a start-of-file byte sees a freshly reset parser
    assign cur_phase = start_of_file ? bsf_pkg::PH_HEADER : phase_reg;
    assign pos       = start_of_file ? 32'd0 : pos_reg;
    assign pos6      = pos[5:0];
    assign do_pixel  = (cur_phase == bsf_pkg::PH_PIXELS) ||
                       ((cur_phase == bsf_pkg::PH_SKIP) && (pos == data_start_reg));

    // Header checks, in priority order
    always_comb
    begin
        hdr_err  = 1'b1;
        hdr_code = bsf_pkg::ERR_NOT_BMP;
        if ((width_reg == 32'd0) || width_reg[31] || (height_reg == 32'd0))
            hdr_code = bsf_pkg::ERR_BAD_SIZE;
        else if ((depth_reg != bsf_pkg::DEPTH_24) && (depth_reg != bsf_pkg::DEPTH_32))
            hdr_code = bsf_pkg::ERR_BAD_DEPTH;
        else if (comp_reg != 32'd0)
            hdr_code = bsf_pkg::ERR_COMPRESSED;
        else if (data_start_reg < bsf_pkg::HDR_LEN)
            hdr_code = bsf_pkg::ERR_BAD_OFFSET;
        else if ((width_reg > 32'(MAX_WIDTH)) ||
                 ($signed(height_reg) > $signed(32'(MAX_HEIGHT))) ||
                 ($signed(height_reg) < -$signed(32'(MAX_HEIGHT))))
            hdr_code = bsf_pkg::ERR_TOO_LARGE;
        else
            hdr_err = 1'b0;
    end

    // Row stride in file bytes, rounded up to four
    assign w_lo    = width_reg[WW-1:0];
    assign h_lo    = height_reg[31] ? (HW'(0) - height_reg[HW-1:0]) : height_reg[HW-1:0];
    assign three_w = (RSW+2)'(w_lo) + (RSW+2)'({w_lo, 1'b0}) + (RSW+2)'(3);
    assign rs_calc = (depth_reg == bsf_pkg::DEPTH_32) ? RSW'({w_lo, 2'b00})
                                                      : RSW'({three_w[RSW+1:2], 2'b00});

    // Clip window and pixel position
    assign dw        = (CW'(img_w_reg) < CW'(cfg.screen_width)) ? CW'(img_w_reg)
                                                                : CW'(cfg.screen_width);
    assign dh        = (CH'(abs_h_reg) < CH'(cfg.screen_height)) ? CH'(abs_h_reg)
                                                                 : CH'(cfg.screen_height);
    assign rows_done = CH'(row_reg) >= dh;
    assign in_clip   = XW'(x_reg) < XW'(dw);
    assign emit      = in_clip && (k_reg == bsf_pkg::LANE_RED);
    assign row_inc   = (HW+1)'(row_reg) + (HW+1)'(1);
    assign x_inc     = (RSW+1)'(x_reg) + (RSW+1)'(1);
    assign rbc_inc   = (RSW+1)'(rbc_reg) + (RSW+1)'(1);
    assign is_last   = emit && ((CH+1)'(row_inc) == (CH+1)'(dh)) &&
                       ((XW+1)'(x_inc) == (XW+1)'(dw));
    assign row_end   = rbc_inc >= (RSW+1)'(stride_reg);
    assign k_wrap    = bpb4_reg ? (k_reg == bsf_pkg::LANE_PAD) : (k_reg == bsf_pkg::LANE_RED);

    // Bottom-up images are flipped vertically
    assign sy   = neg_reg ? CH'(row_reg) : CH'(dh - CH'(1) - CH'(row_reg));
    assign prod = PW'(sy) * PW'(cfg.line_bytes);

    // Next state and result
    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        data_start_next = data_start_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        depth_next      = depth_reg;
        comp_next       = comp_reg;
        img_w_next      = img_w_reg;
        abs_h_next      = abs_h_reg;
        neg_next        = neg_reg;
        bpb4_next       = bpb4_reg;
        stride_next     = stride_reg;
        row_next        = row_reg;
        rbc_next        = rbc_reg;
        x_next          = x_reg;
        k_next          = k_reg;
        pix_next        = pix_reg;
        lane            = 2'(pos6 - bsf_pkg::OFS_DATA_START);
        res_valid       = 1'b0;
        res             = '0;

        if (step)
        begin
            pos_next   = pos + 32'd1;
            phase_next = cur_phase;

            if (cur_phase == bsf_pkg::PH_HEADER)
            begin
                // Capture little-endian header fields
                if (pos6 inside {[bsf_pkg::OFS_DATA_START : bsf_pkg::OFS_DATA_START + 6'd3]})
                begin
                    lane = 2'(pos6 - bsf_pkg::OFS_DATA_START);
                    data_start_next[{lane, 3'b000} +: 8] = file_byte;
                end
                else if (pos6 inside {[bsf_pkg::OFS_WIDTH : bsf_pkg::OFS_WIDTH + 6'd3]})
                begin
                    lane = 2'(pos6 - bsf_pkg::OFS_WIDTH);
                    width_next[{lane, 3'b000} +: 8] = file_byte;
                end
                else if (pos6 inside {[bsf_pkg::OFS_HEIGHT : bsf_pkg::OFS_HEIGHT + 6'd3]})
                begin
                    lane = 2'(pos6 - bsf_pkg::OFS_HEIGHT);
                    height_next[{lane, 3'b000} +: 8] = file_byte;
                end
                else if (pos6 inside {[bsf_pkg::OFS_DEPTH : bsf_pkg::OFS_DEPTH + 6'd1]})
                begin
                    lane = 2'(pos6 - bsf_pkg::OFS_DEPTH);
                    depth_next[{lane[0], 3'b000} +: 8] = file_byte;
                end
                else if (pos6 inside {[bsf_pkg::OFS_COMP : bsf_pkg::OFS_COMP + 6'd3]})
                begin
                    lane = 2'(pos6 - bsf_pkg::OFS_COMP);
                    comp_next[{lane, 3'b000} +: 8] = file_byte;
                end

                // Magic bytes and end-of-header checks
                if (((pos6 == bsf_pkg::OFS_MAGIC_B) && (file_byte != bsf_pkg::MAGIC_B)) ||
                    ((pos6 == bsf_pkg::OFS_MAGIC_M) && (file_byte != bsf_pkg::MAGIC_M)))
                begin
                    res_valid      = 1'b1;
                    res.kind       = bsf_pkg::KIND_ERROR;
                    res.error_code = bsf_pkg::ERR_NOT_BMP;
                    phase_next     = bsf_pkg::PH_DONE;
                end
                else if (pos6 == bsf_pkg::OFS_HDR_LAST)
                begin
                    if (hdr_err)
                    begin
                        res_valid      = 1'b1;
                        res.kind       = bsf_pkg::KIND_ERROR;
                        res.error_code = hdr_code;
                        phase_next     = bsf_pkg::PH_DONE;
                    end
                    else
                    begin
                        img_w_next    = w_lo;
                        abs_h_next    = h_lo;
                        neg_next      = height_reg[31];
                        bpb4_next     = (depth_reg == bsf_pkg::DEPTH_32);
                        stride_next   = rs_calc;
                        row_next      = '0;
                        rbc_next      = '0;
                        x_next        = '0;
                        k_next        = bsf_pkg::LANE_BLUE;
                        pix_next      = '0;
                        phase_next    = (data_start_reg == bsf_pkg::HDR_LEN) ?
                                        bsf_pkg::PH_PIXELS : bsf_pkg::PH_SKIP;
                    end
                end
            end
            else if (do_pixel)
            begin
                phase_next = bsf_pkg::PH_PIXELS;
                if (rows_done)
                begin
                    phase_next = bsf_pkg::PH_DONE;
                end
                else
                begin
                    // Collect the pixel bytes inside the clip window
                    if (in_clip)
                    begin
                        case (k_reg)
                            bsf_pkg::LANE_BLUE:  pix_next[7:0]  = file_byte;
                            bsf_pkg::LANE_GREEN: pix_next[15:8] = file_byte;
                            default:             pix_next       = pix_reg;
                        endcase
                    end
                    if (emit)
                    begin
                        res_valid         = 1'b1;
                        res.kind          = bsf_pkg::KIND_PIXEL;
                        res.write_address = bsf_pkg::ADDR_W'(prod) +
                                            bsf_pkg::ADDR_W'({x_reg, 2'b00});
                        res.pixel_color   = {file_byte, pix_reg};
                        res.last_pixel    = is_last;
                    end

                    // Advance through the row, wrapping at the padded stride
                    if (is_last)
                    begin
                        phase_next = bsf_pkg::PH_DONE;
                    end
                    else if (row_end)
                    begin
                        rbc_next = '0;
                        x_next   = '0;
                        k_next   = bsf_pkg::LANE_BLUE;
                        row_next = HW'(row_inc);
                        if ((CH+1)'(row_inc) >= (CH+1)'(dh))
                            phase_next = bsf_pkg::PH_DONE;
                    end
                    else
                    begin
                        rbc_next = RSW'(rbc_inc);
                        if (k_wrap)
                        begin
                            k_next = bsf_pkg::LANE_BLUE;
                            x_next = RSW'(x_inc);
                        end
                        else
                        begin
                            k_next = k_reg + 2'd1;
                        end
                    end
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bsf_pkg::PH_HEADER;
            pos_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    // Header fields, geometry and counters
    always_ff @(posedge clk)
    begin
        data_start_reg <= data_start_next;
        width_reg      <= width_next;
        height_reg     <= height_next;
        depth_reg      <= depth_next;
        comp_reg       <= comp_next;
        img_w_reg      <= img_w_next;
        abs_h_reg      <= abs_h_next;
        neg_reg        <= neg_next;
        bpb4_reg       <= bpb4_next;
        stride_reg     <= stride_next;
        row_reg        <= row_next;
        rbc_reg        <= rbc_next;
        x_reg          <= x_next;
        k_reg          <= k_next;
        pix_reg        <= pix_next;
    end

endmodule

### tb/sv/bmp_stream_to_framebuffer_tb.sv
module bmp_stream_to_framebuffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsf_pkg::*;

    typedef enum int {MAGIC_GOOD, MAGIC_BAD_FIRST, MAGIC_BAD_SECOND} magic_t;
    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    bsf_byte_if   bif();
    bsf_result_if rif();
    bsf_cfg_if    cif();

    bmp_stream_to_framebuffer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cif),
        .bytes   (bif),
        .results (rif)
    );

    // 2 ns clock
    always #1 clk = ~clk;

    // Decoder shadow state
    cfg_t        cfg_cur;
    phase_t      parse_phase;
    logic [31:0] pos_count;
    logic [31:0] pix_offset;
    logic [31:0] img_width;
    logic [31:0] img_height;
    logic [15:0] img_depth;
    logic [31:0] img_comp;
    logic [31:0] row_idx;
    logic [31:0] row_byte_idx;
    logic [15:0] color_hold;

    result_t     expected_writes[$];
    result_t     oldest;
    int          mismatch_count = 0;
    int          file_items = 0;
    int          burst_left = 0;
    int          gap_len;
    rx_mode_t    rx_mode;
    int          rx_left = 0;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
    endtask

    task automatic clear_parser();
        parse_phase  = PH_HEADER;
        pos_count    = '0;
        pix_offset   = '0;
        img_width    = '0;
        img_height   = '0;
        img_depth    = '0;
        img_comp     = '0;
        row_idx      = '0;
        row_byte_idx = '0;
        color_hold   = '0;
    endtask

    function automatic logic [31:0] height_mag();
        return img_height[31] ? (32'd0 - img_height) : img_height;
    endfunction

    task automatic push_error(logic [CODE_W-1:0] code);
        result_t r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        expected_writes.push_back(r);
        parse_phase = PH_DONE;
    endtask

    // Header bytes: magic check at once, field capture, all other checks at the last byte
    task automatic parse_header(logic [31:0] pos, logic [7:0] b);
        int lane;
        if (pos == 32'(OFS_MAGIC_B) && b != MAGIC_B)
        begin
            push_error(ERR_NOT_BMP);
            return;
        end
        if (pos == 32'(OFS_MAGIC_M) && b != MAGIC_M)
        begin
            push_error(ERR_NOT_BMP);
            return;
        end
        if (pos >= 32'(OFS_DATA_START) && pos < 32'(OFS_DATA_START) + 32'd4)
        begin
            lane = int'(pos - 32'(OFS_DATA_START));
            pix_offset[8*lane +: 8] = b;
        end
        else if (pos >= 32'(OFS_WIDTH) && pos < 32'(OFS_WIDTH) + 32'd4)
        begin
            lane = int'(pos - 32'(OFS_WIDTH));
            img_width[8*lane +: 8] = b;
        end
        else if (pos >= 32'(OFS_HEIGHT) && pos < 32'(OFS_HEIGHT) + 32'd4)
        begin
            lane = int'(pos - 32'(OFS_HEIGHT));
            img_height[8*lane +: 8] = b;
        end
        else if (pos >= 32'(OFS_DEPTH) && pos < 32'(OFS_DEPTH) + 32'd2)
        begin
            lane = int'(pos - 32'(OFS_DEPTH));
            img_depth[8*lane +: 8] = b;
        end
        else if (pos >= 32'(OFS_COMP) && pos < 32'(OFS_COMP) + 32'd4)
        begin
            lane = int'(pos - 32'(OFS_COMP));
            img_comp[8*lane +: 8] = b;
        end
        if (pos != 32'(OFS_HDR_LAST))
            return;
        if (img_width == 0 || img_width[31] || img_height == 0)
            push_error(ERR_BAD_SIZE);
        else if (img_depth != DEPTH_24 && img_depth != DEPTH_32)
            push_error(ERR_BAD_DEPTH);
        else if (img_comp != 0)
            push_error(ERR_COMPRESSED);
        else if (pix_offset < HDR_LEN)
            push_error(ERR_BAD_OFFSET);
        else if (img_width > MAX_WIDTH_DEFAULT || height_mag() > MAX_HEIGHT_DEFAULT)
            push_error(ERR_TOO_LARGE);
        else
        begin
            row_idx      = '0;
            row_byte_idx = '0;
            color_hold   = '0;
            parse_phase  = (pix_offset == HDR_LEN) ? PH_PIXELS : PH_SKIP;
        end
    endtask

    // Pixel bytes: BGR(X) gather, clip, flip, padding skip
    task automatic parse_pixel(logic [7:0] b);
        logic [31:0] bpb, ah, dw, dh, row_stride, x, k, sy;
        logic [63:0] addr_full;
        logic        last;
        result_t     r;
        bpb        = 32'(img_depth) / 32'd8;
        ah         = height_mag();
        dw         = (img_width < 32'(cfg_cur.screen_width)) ? img_width
                                                             : 32'(cfg_cur.screen_width);
        dh         = (ah < 32'(cfg_cur.screen_height)) ? ah : 32'(cfg_cur.screen_height);
        row_stride = ((img_width * 32'(img_depth) + 32'd31) / 32'd32) * 32'd4;
        if (bpb == 0 || row_idx >= dh)
        begin
            parse_phase = PH_DONE;
            return;
        end
        x = row_byte_idx / bpb;
        k = row_byte_idx % bpb;
        if (x < dw)
        begin
            if (k == 32'(LANE_BLUE))
                color_hold[7:0] = b;
            else if (k == 32'(LANE_GREEN))
                color_hold[15:8] = b;
            else if (k == 32'(LANE_RED))
            begin
                sy   = img_height[31] ? row_idx : (dh - 32'd1 - row_idx);
                last = (row_idx == dh - 32'd1) && (x == dw - 32'd1);
                addr_full       = {32'd0, sy} * {48'd0, cfg_cur.line_bytes} +
                                  {32'd0, x} * 64'd4;
                r               = '0;
                r.kind          = KIND_PIXEL;
                r.write_address = addr_full[ADDR_W-1:0];
                r.pixel_color   = {b, color_hold};
                r.last_pixel    = last;
                expected_writes.push_back(r);
                if (last)
                begin
                    parse_phase = PH_DONE;
                    return;
                end
            end
        end
        row_byte_idx = row_byte_idx + 32'd1;
        if (row_byte_idx >= row_stride)
        begin
            row_byte_idx = '0;
            row_idx      = row_idx + 32'd1;
            if (row_idx >= dh)
                parse_phase = PH_DONE;
        end
    endtask

    task automatic predict_byte(logic [7:0] b, logic sof);
        logic [31:0] pos;
        if (sof)
            clear_parser();
        pos       = pos_count;
        pos_count = pos_count + 32'd1;
        case (parse_phase)
            PH_HEADER: parse_header(pos, b);
            PH_SKIP:
            begin
                if (pos == pix_offset)
                begin
                    parse_phase = PH_PIXELS;
                    parse_pixel(b);
                end
            end
            PH_PIXELS: parse_pixel(b);
            default: ;
        endcase
    endtask

    // One byte item; sender works in bursts with random gaps
    task automatic send_byte(logic [7:0] b, logic sof);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap_len    = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap_len)
            begin
                @(negedge clk);
                bif.valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        bif.valid         = 1'b1;
        bif.file_byte     = b;
        bif.start_of_file = sof;
        @(posedge clk);
        while (!bif.ready)
            @(posedge clk);
        predict_byte(b, sof);
    endtask

    task automatic send_raw(int n, int sof_pct);
        repeat (n)
            send_byte(8'($urandom), $urandom_range(0, 99) < sof_pct);
    endtask

    // Stop sending, wait for every result, then cover the pipeline latency
    task automatic settle_pipeline();
        @(negedge clk);
        bif.valid = 1'b0;
        while (expected_writes.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cif.valid = 1'b1;
        cif.index = idx;
        cif.data  = val;
        @(posedge clk);
        while (!cif.ready)
            @(posedge clk);
        case (idx)
            CFG_SCREEN_WIDTH:  cfg_cur.screen_width  = val[SCR_W-1:0];
            CFG_SCREEN_HEIGHT: cfg_cur.screen_height = val[SCR_W-1:0];
            CFG_LINE_BYTES:    cfg_cur.line_bytes    = val[LINE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cif.valid = 1'b0;
    endtask

    // Whole file: header, skip gap, pixel rows (capped), trailing bytes
    task automatic send_file(logic [31:0] w, logic [31:0] h, logic [15:0] depth,
                             logic [31:0] comp, logic [31:0] ofs, magic_t magic,
                             int body_cap, int extra, logic lead_sof);
        logic [7:0]  hdr [54];
        logic [7:0]  b;
        logic [31:0] hmag;
        longint      body;
        for (int i = 0; i < 54; i++)
            hdr[i] = 8'($urandom);
        hdr[OFS_MAGIC_B] = MAGIC_B;
        hdr[OFS_MAGIC_M] = MAGIC_M;
        if (magic == MAGIC_BAD_FIRST)
        begin
            do b = 8'($urandom); while (b == MAGIC_B);
            hdr[OFS_MAGIC_B] = b;
        end
        else if (magic == MAGIC_BAD_SECOND)
        begin
            do b = 8'($urandom); while (b == MAGIC_M);
            hdr[OFS_MAGIC_M] = b;
        end
        for (int i = 0; i < 4; i++)
        begin
            hdr[OFS_DATA_START + i] = ofs[8*i +: 8];
            hdr[OFS_WIDTH + i]      = w[8*i +: 8];
            hdr[OFS_HEIGHT + i]     = h[8*i +: 8];
            hdr[OFS_COMP + i]       = comp[8*i +: 8];
        end
        hdr[OFS_DEPTH]     = depth[7:0];
        hdr[OFS_DEPTH + 1] = depth[15:8];

        hmag = h[31] ? (32'd0 - h) : h;
        if (w > 8192 || hmag > 8192)
            body = 0;
        else
            body = ((longint'(w) * depth + 31) / 32) * 4 * hmag;
        if (ofs > HDR_LEN && ofs < 1000)
            body += ofs - HDR_LEN;
        if (body > body_cap)
            body = body_cap;

        for (int i = 0; i < 54; i++)
            send_byte(hdr[i], (i == 0) ? lead_sof : 1'b0);
        for (longint i = 0; i < body; i++)
            send_byte(8'($urandom), 1'b0);
        repeat (extra) send_byte(8'($urandom), 1'b0);
        file_items += 54 + int'(body);
    endtask

    task automatic shuffle_config();
        logic [CFG_DATA_W-1:0] v;
        settle_pipeline();
        case ($urandom_range(0, 5))
            0:       v = 16'd0;
            1:       v = 16'd1;
            4:       v = 16'd4096;
            5:       v = 16'(SCREEN_WIDTH_RST);
            default: v = 16'($urandom_range(2, 6));
        endcase
        write_reg(CFG_SCREEN_WIDTH, v);
        case ($urandom_range(0, 5))
            0:       v = 16'd0;
            1:       v = 16'd1;
            4:       v = 16'd4096;
            5:       v = 16'(SCREEN_HEIGHT_RST);
            default: v = 16'($urandom_range(2, 5));
        endcase
        write_reg(CFG_SCREEN_HEIGHT, v);
        case ($urandom_range(0, 2))
            0:       v = 16'd4;
            1:       v = 16'hFFFF;
            default: v = 16'($urandom_range(4, 4096));
        endcase
        write_reg(CFG_LINE_BYTES, v);
    endtask

    // First file after reset carries no start_of_file; top-down with row padding
    task automatic test_no_sof_after_reset();
        send_file(3, -2, DEPTH_24, 0, HDR_LEN, MAGIC_GOOD, 100000, 2, 1'b0);
    endtask

    // 32-bit bottom-up with skip gap, and 24-bit top-down
    task automatic test_orientation();
        send_file(2, 3, DEPTH_32, 0, 60, MAGIC_GOOD, 100000, 1, 1'b1);
        send_file(5, -1, DEPTH_24, 0, HDR_LEN, MAGIC_GOOD, 100000, 0, 1'b1);
    endtask

    task automatic test_bad_magic();
        send_file(2, 2, DEPTH_24, 0, HDR_LEN, MAGIC_BAD_FIRST, 0, 3, 1'b1);
        send_file(2, 2, DEPTH_24, 0, HDR_LEN, MAGIC_BAD_SECOND, 0, 3, 1'b1);
    endtask

    // Size, depth, compression and offset checks, plus one file failing four checks at once
    task automatic test_header_checks();
        send_file(0, 2, DEPTH_24, 0, HDR_LEN, MAGIC_GOOD, 0, 2, 1'b1);
        send_file(32'h8000_0005, 2, DEPTH_24, 0, HDR_LEN, MAGIC_GOOD, 0, 0, 1'b1);
        send_file(3, 0, DEPTH_24, 0, HDR_LEN, MAGIC_GOOD, 0, 0, 1'b1);
        send_file(0, 2, 16'd16, 1, 10, MAGIC_GOOD, 0, 0, 1'b1);
        send_file(3, 2, 16'd16, 0, HDR_LEN, MAGIC_GOOD, 0, 0, 1'b1);
        send_file(3, 2, 16'd0, 0, HDR_LEN, MAGIC_GOOD, 0, 0, 1'b1);
        send_file(3, 2, DEPTH_32, 32'hFFFF_FFFF, HDR_LEN, MAGIC_GOOD, 0, 0, 1'b1);
        send_file(3, 2, DEPTH_24, 1, HDR_LEN, MAGIC_GOOD, 0, 0, 1'b1);
        send_file(3, 2, DEPTH_24, 0, 53, MAGIC_GOOD, 0, 0, 1'b1);
        send_file(3, 2, DEPTH_24, 0, 0, MAGIC_GOOD, 0, 0, 1'b1);
    endtask

    // Size limit edges; limit-sized images only get their first bytes
    task automatic test_size_limits();
        send_file(4097, 2, DEPTH_24, 0, HDR_LEN, MAGIC_GOOD, 0, 0, 1'b1);
        send_file(2, 4097, DEPTH_24, 0, HDR_LEN, MAGIC_GOOD, 0, 0, 1'b1);
        send_file(2, -4097, DEPTH_32, 0, HDR_LEN, MAGIC_GOOD, 0, 0, 1'b1);
        send_file(4096, -4096, DEPTH_24, 0, HDR_LEN, MAGIC_GOOD, 60, 0, 1'b1);
        send_file(4096, 4096, DEPTH_32, 0, HDR_LEN, MAGIC_GOOD, 40, 0, 1'b1);
    endtask

    // Clip to the screen, clip to nothing, stride extremes
    task automatic test_clipping();
        settle_pipeline();
        write_reg(CFG_SCREEN_WIDTH, 16'd3);
        write_reg(CFG_SCREEN_HEIGHT, 16'd2);
        write_reg(CFG_LINE_BYTES, 16'd4);
        send_file(5, 4, DEPTH_24, 0, HDR_LEN, MAGIC_GOOD, 100000, 2, 1'b1);
        settle_pipeline();
        write_reg(CFG_SCREEN_WIDTH, 16'd0);
        send_file(2, 2, DEPTH_32, 0, HDR_LEN, MAGIC_GOOD, 100000, 2, 1'b1);
        settle_pipeline();
        write_reg(CFG_SCREEN_WIDTH, 16'd4);
        write_reg(CFG_SCREEN_HEIGHT, 16'd0);
        send_file(2, -2, DEPTH_24, 0, HDR_LEN, MAGIC_GOOD, 100000, 2, 1'b1);
        settle_pipeline();
        write_reg(CFG_SCREEN_WIDTH, 16'd4096);
        write_reg(CFG_SCREEN_HEIGHT, 16'd4096);
        write_reg(CFG_LINE_BYTES, 16'hFFFF);
        send_file(3, -3, DEPTH_32, 0, 57, MAGIC_GOOD, 100000, 1, 1'b1);
        send_file(3, 4096, DEPTH_24, 0, HDR_LEN, MAGIC_GOOD, 40, 0, 1'b1);
        settle_pipeline();
        // upper data bits beyond the 13-bit register
        write_reg(CFG_SCREEN_WIDTH, 16'hE002);
        write_reg(CFG_SCREEN_HEIGHT, 16'd1);
        send_file(4, 3, DEPTH_24, 0, HDR_LEN, MAGIC_GOOD, 100000, 1, 1'b1);
        settle_pipeline();
        write_reg(CFG_SCREEN_WIDTH, 16'(SCREEN_WIDTH_RST));
        write_reg(CFG_SCREEN_HEIGHT, 16'(SCREEN_HEIGHT_RST));
        write_reg(CFG_LINE_BYTES, LINE_BYTES_RST);
    endtask

    // Clip registers changed between bytes of one image
    task automatic test_config_mid_image();
        send_file(2, 4, DEPTH_24, 0, HDR_LEN, MAGIC_GOOD, 16, 0, 1'b1);
        settle_pipeline();
        // two rows done, new height already reached
        write_reg(CFG_SCREEN_HEIGHT, 16'd1);
        send_raw(10, 0);
        send_file(4, -3, DEPTH_32, 0, HDR_LEN, MAGIC_GOOD, 20, 0, 1'b1);
        settle_pipeline();
        write_reg(CFG_SCREEN_HEIGHT, 16'(SCREEN_HEIGHT_RST));
        write_reg(CFG_SCREEN_WIDTH, 16'd2);
        send_raw(60, 0);
        settle_pipeline();
        write_reg(CFG_SCREEN_WIDTH, 16'(SCREEN_WIDTH_RST));
    endtask

    // start_of_file inside a header and inside pixel data
    task automatic test_restart_mid_file();
        send_byte(MAGIC_B, 1'b1);
        send_byte(MAGIC_M, 1'b0);
        send_raw(20, 0);
        send_file(4, 3, DEPTH_24, 0, HDR_LEN, MAGIC_GOOD, 14, 0, 1'b1);
        send_file(3, -2, DEPTH_32, 0, 56, MAGIC_GOOD, 100000, 0, 1'b1);
    endtask

    // Mostly well-formed files with random content, some broken or cut, some noise
    task automatic test_random_files();
        int          sel;
        int          cap;
        int          start_items;
        logic [31:0] w, h, hm, comp, ofs;
        logic [15:0] depth;
        magic_t      magic;
        start_items = file_items;
        while (file_items - start_items < 200)
        begin
            if ($urandom_range(0, 9) == 0)
                shuffle_config();
            w     = $urandom_range(1, 5);
            hm    = $urandom_range(1, 4);
            h     = $urandom_range(0, 1) ? (32'd0 - hm) : hm;
            depth = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
            ofs   = HDR_LEN + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8));
            comp  = 0;
            magic = MAGIC_GOOD;
            cap   = 100000;
            sel   = $urandom_range(0, 99);
            if (sel >= 93)
            begin
                send_raw($urandom_range(1, 12), 20);
                continue;
            end
            if (sel >= 65 && sel < 85)
            begin
                cap = $urandom_range(0, 8);
                case ($urandom_range(0, 8))
                    0: magic = MAGIC_BAD_FIRST;
                    1: magic = MAGIC_BAD_SECOND;
                    2: w = 0;
                    3: w = 32'h8000_0000 | $urandom;
                    4: h = 0;
                    5: do depth = 16'($urandom); while (depth == DEPTH_24 || depth == DEPTH_32);
                    6: comp = ($urandom == 0) ? 1 : $urandom | 1;
                    7: ofs = $urandom_range(0, 53);
                    default:
                    begin
                        if ($urandom_range(0, 1))
                            w = $urandom_range(4097, 65535);
                        else
                            h = $urandom_range(0, 1) ? (32'd0 - $urandom_range(4097, 9000))
                                                     : $urandom_range(4097, 9000);
                    end
                endcase
            end
            else if (sel >= 85)
            begin
                cap = $urandom_range(0, 24);
            end
            send_file(w, h, depth, comp, ofs, magic, cap, $urandom_range(0, 3), 1'b1);
            // cut file resumed under new clip settings
            if (sel >= 85 && $urandom_range(0, 1))
            begin
                shuffle_config();
                send_raw($urandom_range(1, 40), 0);
            end
        end
    endtask

    // Receiver ready pattern: free runs, coin flips, sparse, periodic stall runs
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:   rif.ready = 1'b1;
            RX_COIN:   rif.ready = 1'($urandom_range(0, 1));
            RX_SPARSE: rif.ready = ($urandom_range(0, 3) == 0);
            default:   rif.ready = (rx_left % 24) >= 16;
        endcase
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && rif.valid && rif.ready)
        begin
            if (expected_writes.size() == 0)
                report_mismatch("item with none expected", 32'(rif.write_address), 0);
            else
            begin
                oldest = expected_writes.pop_front();
                if (rif.kind !== oldest.kind)
                    report_mismatch("kind", 32'(rif.kind), 32'(oldest.kind));
                if (rif.write_address !== oldest.write_address)
                    report_mismatch("write_address", 32'(rif.write_address),
                                    32'(oldest.write_address));
                if (rif.pixel_color !== oldest.pixel_color)
                    report_mismatch("pixel_color", 32'(rif.pixel_color),
                                    32'(oldest.pixel_color));
                if (rif.error_code !== oldest.error_code)
                    report_mismatch("error_code", 32'(rif.error_code), 32'(oldest.error_code));
                if (rif.last_pixel !== oldest.last_pixel)
                    report_mismatch("last_pixel", 32'(rif.last_pixel), 32'(oldest.last_pixel));
            end
        end
    end

    // Run limit
    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n             = 1'b0;
        bif.valid         = 1'b0;
        bif.file_byte     = '0;
        bif.start_of_file = 1'b0;
        cif.valid         = 1'b0;
        cif.index         = CFG_SCREEN_WIDTH;
        cif.data          = '0;
        cfg_cur.screen_width  = SCREEN_WIDTH_RST;
        cfg_cur.screen_height = SCREEN_HEIGHT_RST;
        cfg_cur.line_bytes    = LINE_BYTES_RST;
        clear_parser();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_no_sof_after_reset();
        test_orientation();
        test_bad_magic();
        test_header_checks();
        test_size_limits();
        test_clipping();
        test_config_mid_image();
        test_restart_mid_file();
        test_random_files();

        // drain and let the pipeline empty
        @(negedge clk);
        bif.valid = 1'b0;
        for (int n = 0; n < 200000 && expected_writes.size() != 0; n++)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (expected_writes.size() != 0)
            report_mismatch("results never arrived", expected_writes.size(), 0);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/bsf_pkg.sv
rtl/core/bsf_if.sv
rtl/core/bsf_cfg_regs.sv
rtl/core/bsf_decoder.sv
rtl/core/bmp_stream_to_framebuffer.sv
tb/sv/bmp_stream_to_framebuffer_tb.sv
